// ----- sv/ksrm_pkg.sv -----
// ----------------------------------------------------------------------------
// ksrm_pkg: shared types and codes of the sorted run merger
// Request and status codes, field widths and the result record.
// ----------------------------------------------------------------------------
package ksrm_pkg;

   localparam int VALUE_W = 32;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_POP   = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_MERGED   = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_REJECTED = 2'd3;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] merged_value;
      logic                      final_element;
   } rsp_type;

endpackage

// ----- sv/ksrm_ifs.sv -----
// ----------------------------------------------------------------------------
// ksrm_ifs: request and response channels of the sorted run merger
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ksrm_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         req_type;
   logic signed [ksrm_pkg::VALUE_W-1:0] value;
   logic                               run_last;

   modport source (output valid, req_type, value, run_last, input ready);
   modport sink (input valid, req_type, value, run_last, output ready);
endinterface

interface ksrm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic signed [ksrm_pkg::VALUE_W-1:0] merged_value;
   logic                               final_element;

   modport source (output valid, status, merged_value, final_element, input ready);
   modport sink (input valid, status, merged_value, final_element, output ready);
endinterface

// ----- sv/ksrm_elem_store.sv -----
// ----------------------------------------------------------------------------
// ksrm_elem_store: element memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ksrm_elem_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [AW-1:0]                      wr_addr,
   input  logic signed [ksrm_pkg::VALUE_W-1:0] wr_data,
   input  logic                               rd_en,
   input  logic [AW-1:0]                      rd_addr,
   output logic signed [ksrm_pkg::VALUE_W-1:0] rd_data
);

   logic signed [ksrm_pkg::VALUE_W-1:0] mem [DEPTH];
   logic signed [ksrm_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/kway_sorted_run_merger.sv -----
// ----------------------------------------------------------------------------
// kway_sorted_run_merger: k-way merge of sorted runs by a linear head scan
// Loads build runs in an element memory; each pop scans the run heads with
// one comparator and emits the smallest value.
// ----------------------------------------------------------------------------
//  Channel   Dir   Fields
//  req_ch    in    req_type, value, run_last
//  rsp_ch    out   status, merged_value, final_element
//
// One item is in work at a time; req_ch is ready only in the idle state. A load,
// clear or rejected item has its result registered in pend_ff and then in rsp_ff
// for rsp_ch; a pop first runs the head scan, which reads one run head per cycle
// into one signed comparator. The block is idle again once the result is
// registered, while it may still wait on rsp_ch; a second waiting result stalls
// the input. Reset is synchronous; memory contents stay undefined.
module kway_sorted_run_merger #(
   parameter int CAPACITY = 1024,
   parameter int MAX_RUNS = 16
) (
   input logic         clock,
   input logic         reset,
   ksrm_req_if.sink    req_ch,
   ksrm_rsp_if.source  rsp_ch
);

   localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IW  = $clog2(CAPACITY + 1);
   localparam int RIW = $clog2(MAX_RUNS);
   localparam int RW  = $clog2(MAX_RUNS + 1);
   localparam int VW  = ksrm_pkg::VALUE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_ADV,
      S_OUT
   } state_type;

   state_type               state_ff;
   logic [IW-1:0]           elem_count_ff;
   logic [IW-1:0]           emitted_ff;
   logic [RW-1:0]           run_count_ff;
   logic                    run_open_ff;
   logic                    merging_ff;
   logic [IW-1:0]           run_head_ff [MAX_RUNS];
   logic [IW-1:0]           run_end_ff [MAX_RUNS];

   logic [RIW-1:0]          scan_idx_ff;
   logic                    cmp_valid_ff;
   logic [RIW-1:0]          cmp_run_ff;
   logic [IW-1:0]           cmp_head_ff;
   logic                    found_ff;
   logic [RIW-1:0]          best_run_ff;
   logic [IW-1:0]           best_head_ff;
   logic signed [VW-1:0]    best_val_ff;

   ksrm_pkg::rsp_type       pend_ff;
   ksrm_pkg::rsp_type       rsp_ff;
   logic                    rsp_valid_ff;

   logic                    accept;
   logic                    load_ok;
   logic [RIW-1:0]          end_slot;
   logic [IW-1:0]           scan_head;
   logic                    scan_live;
   logic                    take_in;
   logic [IW-1:0]           emitted_in;
   logic signed [VW-1:0]    rd_data;
   logic                    store_wr;
   logic                    rsp_load;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   assign load_ok = !merging_ff && (elem_count_ff < IW'(CAPACITY))
                    && (run_open_ff || (run_count_ff < RW'(MAX_RUNS)));
   assign end_slot = run_open_ff ? RIW'(run_count_ff - RW'(1)) : RIW'(run_count_ff);
   assign store_wr = accept && (req_ch.req_type == ksrm_pkg::REQ_LOAD) && load_ok;

   assign scan_head = run_head_ff[scan_idx_ff];
   assign scan_live = (RW'(scan_idx_ff) < run_count_ff)
                      && (scan_head < run_end_ff[scan_idx_ff]);

   // A later run wins only on a strictly smaller value, so ties go low.
   assign take_in    = cmp_valid_ff && (!found_ff || (rd_data < best_val_ff));
   assign emitted_in = emitted_ff + IW'(1);

   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   ksrm_elem_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (elem_count_ff[AW-1:0]),
      .wr_data (req_ch.value),
      .rd_en   ((state_ff == S_SCAN) && scan_live),
      .rd_addr (scan_head[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         elem_count_ff <= '0;
         emitted_ff    <= '0;
         run_count_ff  <= '0;
         run_open_ff   <= 1'b0;
         merging_ff    <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
         scan_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_ff       <= pend_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_ch.req_type)
                     ksrm_pkg::REQ_LOAD: begin
                        state_ff <= S_OUT;
                        if (load_ok) begin
                           if (!run_open_ff) begin
                              run_head_ff[RIW'(run_count_ff)] <= elem_count_ff;
                              run_count_ff <= run_count_ff + RW'(1);
                           end
                           run_end_ff[end_slot] <= elem_count_ff + IW'(1);
                           elem_count_ff        <= elem_count_ff + IW'(1);
                           run_open_ff          <= !req_ch.run_last;
                           pend_ff <= '{status: ksrm_pkg::ST_OK, merged_value: '0,
                                        final_element: 1'b0};
                        end else begin
                           pend_ff <= '{status: ksrm_pkg::ST_REJECTED, merged_value: '0,
                                        final_element: 1'b0};
                        end
                     end
                     ksrm_pkg::REQ_POP: begin
                        merging_ff  <= 1'b1;
                        run_open_ff <= 1'b0;
                        scan_idx_ff <= '0;
                        found_ff    <= 1'b0;
                        state_ff    <= S_SCAN;
                     end
                     ksrm_pkg::REQ_CLEAR: begin
                        elem_count_ff <= '0;
                        emitted_ff    <= '0;
                        run_count_ff  <= '0;
                        run_open_ff   <= 1'b0;
                        merging_ff    <= 1'b0;
                        pend_ff <= '{status: ksrm_pkg::ST_OK, merged_value: '0,
                                     final_element: 1'b0};
                        state_ff      <= S_OUT;
                     end
                     default: begin
                        pend_ff <= '{status: ksrm_pkg::ST_REJECTED, merged_value: '0,
                                     final_element: 1'b0};
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end

            S_SCAN, S_LAST: begin
               // Read of one run head overlaps the compare of the previous one.
               if (take_in) begin
                  found_ff     <= 1'b1;
                  best_run_ff  <= cmp_run_ff;
                  best_head_ff <= cmp_head_ff;
                  best_val_ff  <= rd_data;
               end
               cmp_valid_ff <= (state_ff == S_SCAN) && scan_live;
               cmp_run_ff   <= scan_idx_ff;
               cmp_head_ff  <= scan_head;
               if (state_ff == S_LAST) begin
                  state_ff <= S_ADV;
               end else if (scan_idx_ff == RIW'(MAX_RUNS - 1)) begin
                  state_ff <= S_LAST;
               end else begin
                  scan_idx_ff <= scan_idx_ff + RIW'(1);
               end
            end

            S_ADV: begin
               cmp_valid_ff <= 1'b0;
               if (found_ff) begin
                  run_head_ff[best_run_ff] <= best_head_ff + IW'(1);
                  emitted_ff <= emitted_in;
                  pend_ff <= '{status: ksrm_pkg::ST_MERGED, merged_value: best_val_ff,
                               final_element: (emitted_in == elem_count_ff)};
               end else begin
                  pend_ff <= '{status: ksrm_pkg::ST_EMPTY, merged_value: '0,
                               final_element: 1'b0};
               end
               state_ff <= S_OUT;
            end

            S_OUT: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_ff.status;
   assign rsp_ch.merged_value  = rsp_ff.merged_value;
   assign rsp_ch.final_element = rsp_ff.final_element;

endmodule
